FILE: sv/lfu_pkg.sv
// Shared types and constants for the LFU cache policy block.
`default_nettype none
package lfu_pkg;

   localparam int KEY_W   = 31;
   localparam int DATA_W  = 32;
   localparam int USES_W  = 32;
   localparam int STAMP_W = 32;
   localparam int CSR_W   = 5;

   localparam logic [CSR_W-1:0]  CSR_RESET = 5'd16;
   localparam logic [USES_W-1:0] USES_MAX  = '1;
   localparam logic [USES_W-1:0] USES_NEW  = 32'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [DATA_W-1:0]  data;
      logic [USES_W-1:0]  uses;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic eval;
   } scan_ctl_type;

   typedef struct packed {
      logic              found;
      logic [DATA_W-1:0] match_data;
      logic [USES_W-1:0] match_uses;
      logic              victim_ok;
      logic [KEY_W-1:0]  victim_key;
      logic              free_ok;
   } scan_res_type;

endpackage
`default_nettype wire

FILE: sv/lfu_req_if.sv
// Request channel: access type, key and put data.
`default_nettype none
interface lfu_req_if;
   import lfu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [KEY_W-1:0]         lookup_key;
   logic signed [DATA_W-1:0] put_value;

   modport source (output valid, output req_type, output lookup_key, output put_value,
                   input ready);
   modport sink (input valid, input req_type, input lookup_key, input put_value,
                 output ready);
endinterface
`default_nettype wire

FILE: sv/lfu_rsp_if.sv
// Response channel: hit, read data and eviction report.
`default_nettype none
interface lfu_rsp_if;
   import lfu_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [DATA_W-1:0] read_value;
   logic                     evicted;
   logic [KEY_W-1:0]         evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink (input valid, input hit, input read_value, input evicted,
                 input evicted_key, output ready);
endinterface
`default_nettype wire

FILE: sv/lfu_entry_ram.sv
// Entry store: one write port, one registered read port.
`default_nettype none
module lfu_entry_ram #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire lfu_pkg::entry_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output lfu_pkg::entry_type     rd_data
);
   import lfu_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: sv/lfu_scan.sv
// Scan unit: one entry per cycle, tracks key match, LFU/LRU victim, free slot, occupancy.
`default_nettype none
module lfu_scan #(
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfu_pkg::scan_ctl_type    ctl,
   input  wire logic [AW-1:0]            idx,
   input  wire logic                     entry_vld,
   input  wire lfu_pkg::entry_type       entry,
   input  wire logic [lfu_pkg::KEY_W-1:0] key,
   output lfu_pkg::scan_res_type         res,
   output logic [AW-1:0]                 match_idx,
   output logic [AW-1:0]                 victim_idx,
   output logic [AW-1:0]                 free_idx,
   output logic [CW-1:0]                 used
);
   import lfu_pkg::*;

   logic               found_ff;
   logic               victim_ok_ff;
   logic               free_ok_ff;
   logic [CW-1:0]      used_ff;
   logic [AW-1:0]      match_idx_ff;
   logic [AW-1:0]      victim_idx_ff;
   logic [AW-1:0]      free_idx_ff;
   logic [DATA_W-1:0]  match_data_ff;
   logic [USES_W-1:0]  match_uses_ff;
   logic [USES_W-1:0]  best_uses_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [KEY_W-1:0]   victim_key_ff;
   logic               better;
   logic               take_match;

   // fewer uses wins; on equal uses the older stamp wins; full ties keep the lower slot
   always_comb begin
      better = !victim_ok_ff || (entry.uses < best_uses_ff) ||
               ((entry.uses == best_uses_ff) && (entry.stamp < best_stamp_ff));
      take_match = !found_ff && (entry.key == key);
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         found_ff     <= 1'b0;
         victim_ok_ff <= 1'b0;
         free_ok_ff   <= 1'b0;
         used_ff      <= '0;
      end else if (ctl.eval) begin
         if (entry_vld) begin
            used_ff <= used_ff + CW'(1);
            if (take_match) begin
               found_ff      <= 1'b1;
               match_idx_ff  <= idx;
               match_data_ff <= entry.data;
               match_uses_ff <= entry.uses;
            end
            if (better) begin
               victim_ok_ff  <= 1'b1;
               victim_idx_ff <= idx;
               best_uses_ff  <= entry.uses;
               best_stamp_ff <= entry.stamp;
               victim_key_ff <= entry.key;
            end
         end else if (!free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= idx;
         end
      end
   end

   always_comb begin
      res.found      = found_ff;
      res.match_data = match_data_ff;
      res.match_uses = match_uses_ff;
      res.victim_ok  = victim_ok_ff;
      res.victim_key = victim_key_ff;
      res.free_ok    = free_ok_ff;
      match_idx      = match_idx_ff;
      victim_idx     = victim_idx_ff;
      free_idx       = free_idx_ff;
      used           = used_ff;
   end

endmodule
`default_nettype wire

FILE: sv/lfu_cache_policy.sv
// LFU cache with LRU tie-break: top level with sequencer, valid bits and response register.
// Flow: IDLE accepts a request; SCAN reads each slot through the registered read port of the
//   entry store and the scan unit evaluates it; UPDATE writes any entry, loads the response
//   register, and waits while an earlier response is still held and not taken. Only one
//   request is in flight: the next is accepted only after the return to IDLE.
// Reset: synchronous; clears all valid bits, the access clock and the response valid,
//   and sets the capacity register to 16. Entry contents are not cleared.
`default_nettype none
module lfu_cache_policy #(
   parameter int CAPACITY = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [lfu_pkg::CSR_W-1:0] csr_wr_data,
   lfu_req_if.sink                        req_chan,
   lfu_rsp_if.source                      rsp_chan
);
   import lfu_pkg::*;

   localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > CSR_W) ? CW : CSR_W;

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   csr_ff, csr_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [STAMP_W-1:0] clock_ff, clock_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               eval_ff;
   logic [AW-1:0]      eval_idx_ff;

   logic               is_put_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [DATA_W-1:0]  value_ff;
   logic               cap_zero_ff;

   logic               rsp_hit_ff;
   logic [DATA_W-1:0]  rsp_data_ff;
   logic               rsp_evicted_ff;
   logic [KEY_W-1:0]   rsp_evkey_ff;

   logic               req_ready;
   logic               accept;
   logic               issue;
   logic               commit;
   scan_ctl_type       scan_ctl;
   scan_res_type       scan_res;
   logic [AW-1:0]      match_idx;
   logic [AW-1:0]      victim_idx;
   logic [AW-1:0]      free_idx;
   logic [CW-1:0]      used;
   entry_type          rd_entry;

   logic [CMPW-1:0]    cap_req;
   logic [CMPW-1:0]    cap_lim;
   logic               is_hit;
   logic               do_ins;
   logic               do_evict;
   logic               mem_wr;
   logic [AW-1:0]      wr_addr;
   entry_type          wr_entry;
   logic [USES_W-1:0]  uses_bump;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CW'(CAPACITY)) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   issue = (cnt_ff != CW'(CAPACITY));
         ST_UPDATE: commit = !rsp_valid_ff || rsp_chan.ready;
         default:   req_ready = 1'b0;
      endcase
   end

   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign scan_ctl       = '{clear: accept, eval: eval_ff};

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = '0;
      end else if (issue) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_comb begin
      csr_in = csr_wr_en ? csr_wr_data : csr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         csr_ff   <= CSR_RESET;
         cnt_ff   <= '0;
         eval_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         csr_ff   <= csr_in;
         cnt_ff   <= cnt_in;
         eval_ff  <= issue;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff <= cnt_ff[AW-1:0];
      if (accept) begin
         is_put_ff   <= req_chan.req_type;
         key_ff      <= req_chan.lookup_key;
         value_ff    <= req_chan.put_value;
         cap_zero_ff <= (csr_ff == '0);
      end
   end

   // ---------------- entry store and scan ----------------
   lfu_entry_ram #(.DEPTH(CAPACITY)) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (issue),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   lfu_scan #(.DEPTH(CAPACITY)) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .idx        (eval_idx_ff),
      .entry_vld  (valid_ff[eval_idx_ff]),
      .entry      (rd_entry),
      .key        (key_ff),
      .res        (scan_res),
      .match_idx  (match_idx),
      .victim_idx (victim_idx),
      .free_idx   (free_idx),
      .used       (used)
   );

   // ---------------- update ----------------
   always_comb begin
      cap_req   = CMPW'(csr_ff);
      cap_lim   = (cap_req > CMPW'(CAPACITY)) ? CMPW'(CAPACITY) : cap_req;
      is_hit    = !cap_zero_ff && scan_res.found;
      do_ins    = !cap_zero_ff && !scan_res.found && is_put_ff;
      // store full (or shrunk below occupancy): replace the LFU/LRU entry
      do_evict  = do_ins && (CMPW'(used) >= cap_lim) && scan_res.victim_ok;
      uses_bump = (scan_res.match_uses == USES_MAX) ? scan_res.match_uses
                                                    : scan_res.match_uses + USES_W'(1);
      mem_wr    = commit && (is_hit || (do_ins && (do_evict || scan_res.free_ok)));
      wr_entry.key   = key_ff;
      wr_entry.stamp = clock_ff;
      if (is_hit) begin
         wr_addr       = match_idx;
         wr_entry.data = is_put_ff ? value_ff : scan_res.match_data;
         wr_entry.uses = uses_bump;
      end else begin
         wr_addr       = do_evict ? victim_idx : free_idx;
         wr_entry.data = value_ff;
         wr_entry.uses = USES_NEW;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (mem_wr && do_ins) begin
         valid_in[wr_addr] = 1'b1;
      end
      clock_in = mem_wr ? clock_ff + STAMP_W'(1) : clock_ff;
      rsp_valid_in = commit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         clock_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         clock_ff     <= clock_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_hit_ff     <= is_hit;
         rsp_data_ff    <= (is_hit && !is_put_ff) ? scan_res.match_data : '0;
         rsp_evicted_ff <= do_evict;
         rsp_evkey_ff   <= do_evict ? scan_res.victim_key : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.read_value  = $signed(rsp_data_ff);
   assign rsp_chan.evicted     = rsp_evicted_ff;
   assign rsp_chan.evicted_key = rsp_evkey_ff;

   // ---------------- assertions ----------------
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN) && (cnt_ff == '0))
      else $error("scan did not start after request accept");

   a_fill_free_slot: assert property (@(posedge clock) disable iff (reset)
      (mem_wr && do_ins && !do_evict) |-> !valid_ff[wr_addr])
      else $error("insert without eviction hit an occupied slot");

   a_victim_valid: assert property (@(posedge clock) disable iff (reset)
      (commit && do_evict) |-> valid_ff[victim_idx])
      else $error("evicted slot was not valid");

   a_clock_step: assert property (@(posedge clock) disable iff (reset)
      mem_wr |=> (clock_ff == $past(clock_ff) + STAMP_W'(1)))
      else $error("access clock did not advance on entry write");

   a_no_write_on_zero: assert property (@(posedge clock) disable iff (reset)
      (commit && cap_zero_ff) |-> !mem_wr)
      else $error("entry written with capacity zero");

endmodule
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for lfu_cache_policy: scoreboard-driven get/put traffic over many capacities.
module tb;
   import lfu_pkg::*;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int KEY_POOL_N  = 48;
   localparam int DRAIN_WAIT  = 2 * SLOTS + 8;

   typedef enum bit {OP_GET = 1'b0, OP_PUT = 1'b1} op_kind_type;

   typedef struct packed {
      op_kind_type       op;
      logic [KEY_W-1:0]  key;
      logic [DATA_W-1:0] value;
   } cache_access_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
      logic              evicted;
      logic [KEY_W-1:0]  evicted_key;
   } cache_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]  csr_wr_data = '0;
   logic              req_valid   = 1'b0;
   logic              req_type_d  = 1'b0;
   logic [KEY_W-1:0]  req_key     = '0;
   logic [DATA_W-1:0] req_value   = '0;
   logic              rsp_ready   = 1'b0;
   logic              req_fire    = 1'b0;

   lfu_req_if req_bus();
   lfu_rsp_if rsp_bus();

   assign req_bus.valid      = req_valid;
   assign req_bus.req_type   = req_type_d;
   assign req_bus.lookup_key = req_key;
   assign req_bus.put_value  = req_value;
   assign rsp_bus.ready      = rsp_ready;

   lfu_cache_policy #(.CAPACITY(SLOTS)) DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus)
   );

   always #5 clock = ~clock;

   // Mirror of the cache contents
   bit                cache_valid [SLOTS];
   logic [KEY_W-1:0]  cache_key   [SLOTS];
   logic [DATA_W-1:0] cache_data  [SLOTS];
   logic [USES_W-1:0] cache_uses  [SLOTS];
   logic [STAMP_W-1:0] cache_stamp [SLOTS];
   logic [STAMP_W-1:0] access_tick;
   logic [CSR_W-1:0]  cap_limit;

   cache_access_type pending_accesses[$];
   cache_result_type expected_results[$];
   logic [KEY_W-1:0] key_pool[KEY_POOL_N];

   int  issued_count   = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  failures       = 0;
   int  hit_total      = 0;
   int  evict_total    = 0;
   int  cap_writes     = 0;
   int  req_gap        = 0;
   int  rsp_stall      = 0;
   int  cycle_count    = 0;
   bit  no_idle        = 1'b0;

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void bump_entry(int slot);
      if (cache_uses[slot] != USES_MAX)
         cache_uses[slot] = cache_uses[slot] + USES_W'(1);
      cache_stamp[slot] = access_tick;
      access_tick = access_tick + STAMP_W'(1);
   endfunction

   function automatic cache_result_type lfu_lookup(cache_access_type acc);
      cache_result_type r;
      int limit;
      int match_slot;
      int victim;
      int occupied;
      r = '0;
      limit = (int'(cap_limit) > SLOTS) ? SLOTS : int'(cap_limit);
      if (limit == 0) return r;
      match_slot = -1;
      occupied = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (cache_valid[i]) begin
            occupied++;
            if (match_slot < 0 && cache_key[i] == acc.key) match_slot = i;
         end
      end
      if (match_slot >= 0) begin
         r.hit = 1'b1;
         if (acc.op == OP_PUT) cache_data[match_slot] = acc.value;
         else r.read_value = cache_data[match_slot];
         bump_entry(match_slot);
         return r;
      end
      if (acc.op == OP_GET) return r;
      victim = -1;
      if (occupied >= limit) begin
         // lowest use count wins, older stamp breaks ties, then lowest slot
         for (int i = 0; i < SLOTS; i++) begin
            if (!cache_valid[i]) continue;
            if (victim < 0 || cache_uses[i] < cache_uses[victim] ||
                (cache_uses[i] == cache_uses[victim] && cache_stamp[i] < cache_stamp[victim]))
               victim = i;
         end
         if (victim >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = cache_key[victim];
         end
      end
      if (victim < 0) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (!cache_valid[i]) begin
               victim = i;
               break;
            end
         end
      end
      if (victim < 0) return r;
      cache_valid[victim] = 1'b1;
      cache_key[victim]   = acc.key;
      cache_data[victim]  = acc.value;
      cache_uses[victim]  = USES_NEW;
      cache_stamp[victim] = access_tick;
      access_tick = access_tick + STAMP_W'(1);
      return r;
   endfunction

   function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                         logic [DATA_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%h, got 0x%h", name, want, got);
         failures++;
      end
   endfunction

   // Request driver: holds a request until accepted, then idles or moves on.
   always @(negedge clock) begin : req_driver
      cache_access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap == 0 && pending_accesses.size() != 0) begin
            nxt = pending_accesses.pop_front();
            req_valid  <= 1'b1;
            req_type_d <= nxt.op;
            req_key    <= nxt.key;
            req_value  <= nxt.value;
            req_gap = no_idle ? 0 : pick_gap();
         end else begin
            if (req_gap != 0) req_gap--;
            req_valid  <= 1'b0;
            // junk on the payload while valid is low
            req_type_d <= 1'($urandom_range(0, 1));
            req_key    <= KEY_W'($urandom());
            req_value  <= DATA_W'($urandom());
         end
      end
   end

   always @(negedge clock) begin : rsp_ready_driver
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
   end

   // Monitor: predicts on request accept, checks on response accept.
   always @(posedge clock) begin : monitor
      cache_access_type acc;
      cache_result_type want;
      req_fire <= !reset && req_valid && req_bus.ready;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_data[i]  = '0;
            cache_uses[i]  = '0;
            cache_stamp[i] = '0;
         end
         access_tick = '0;
         cap_limit = CSR_RESET;
      end else begin
         if (csr_wr_en) cap_limit = csr_wr_data;
         if (req_valid && req_bus.ready) begin
            acc.op    = op_kind_type'(req_type_d);
            acc.key   = req_key;
            acc.value = req_value;
            want = lfu_lookup(acc);
            if (want.hit) hit_total++;
            if (want.evicted) evict_total++;
            expected_results.push_back(want);
            accepted_count++;
         end
         if (rsp_bus.valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding (key 0x%h)", rsp_bus.evicted_key);
               failures++;
            end else begin
               want = expected_results.pop_front();
               compare_field("hit", DATA_W'(want.hit), DATA_W'(rsp_bus.hit));
               compare_field("read_value", want.read_value, rsp_bus.read_value);
               compare_field("evicted", DATA_W'(want.evicted), DATA_W'(rsp_bus.evicted));
               compare_field("evicted_key", DATA_W'(want.evicted_key),
                             DATA_W'(rsp_bus.evicted_key));
               checked_count++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due",
                  cycle_count, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_access(op_kind_type op, logic [KEY_W-1:0] key,
                               logic [DATA_W-1:0] value);
      cache_access_type acc;
      acc.op    = op;
      acc.key   = key;
      acc.value = value;
      pending_accesses.push_back(acc);
      issued_count++;
   endtask

   // Called at a falling edge; returns at a falling edge with the block idle.
   task automatic wait_idle();
      while (accepted_count != issued_count || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_capacity(logic [CSR_W-1:0] cap);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cap_writes++;
   endtask

   task automatic run_random(logic [CSR_W-1:0] cap, int count, int base, int span, bit calm);
      op_kind_type op;
      logic [KEY_W-1:0] key;
      logic [DATA_W-1:0] value;
      int r;
      set_capacity(cap);
      no_idle = calm;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 99) < 55) ? OP_PUT : OP_GET;
         r = $urandom_range(0, 99);
         if (r < 8) key = KEY_W'($urandom());
         else key = key_pool[base + $urandom_range(0, span - 1)];
         r = $urandom_range(0, 99);
         if (r < 3) value = 32'h8000_0000;
         else if (r < 6) value = 32'h7FFF_FFFF;
         else value = DATA_W'($urandom());
         queue_access(op, key, value);
      end
   endtask

   initial begin : stimulus
      int phase_cap  [11] = '{1, 16, 4, 0, 8, 31, 2, 17, 5, 3, 16};
      int phase_n    [11] = '{40, 70, 50, 25, 60, 60, 45, 50, 45, 40, 65};
      int phase_base [11] = '{0, 0, 4, 0, 2, 0, 10, 0, 20, 30, 0};
      int phase_span [11] = '{3, 22, 8, 10, 12, 24, 5, 20, 9, 6, 48};
      bit phase_calm [11] = '{0, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0};
      logic [KEY_W-1:0] key_max;
      key_max = '1;
      for (int i = 0; i < KEY_POOL_N; i++)
         key_pool[i] = (i % 2 == 0) ? KEY_W'(i) : KEY_W'($urandom());
      key_pool[0] = '0;
      key_pool[1] = key_max;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes of key and data, hits, misses, updates
      queue_access(OP_GET, key_max, 32'h1234_5678);
      queue_access(OP_PUT, key_max, 32'h8000_0000);
      queue_access(OP_PUT, '0, 32'h7FFF_FFFF);
      queue_access(OP_GET, key_max, '0);
      queue_access(OP_GET, '0, '1);
      queue_access(OP_PUT, '0, 32'hFFFF_FFFF);
      queue_access(OP_GET, '0, '0);
      queue_access(OP_GET, 31'h2AAA_AAAA, '0);
      queue_access(OP_PUT, 31'h5555_5555, 32'h5555_5555);
      // capacity lowered below occupancy: each new key evicts one
      set_capacity(5'd2);
      queue_access(OP_PUT, 31'd7, 32'hAAAA_AAAA);
      queue_access(OP_PUT, 31'd9, 32'h0000_0001);
      queue_access(OP_GET, '0, '0);
      // zero capacity: everything misses, puts are dropped
      set_capacity(5'd0);
      queue_access(OP_GET, '0, '0);
      queue_access(OP_PUT, '0, 32'hDEAD_BEEF);
      queue_access(OP_PUT, 31'd77, 32'h0BAD_F00D);
      // above the slot count acts as full size; held entries come back
      set_capacity(5'd31);
      queue_access(OP_GET, '0, '0);
      queue_access(OP_GET, 31'd9, '0);
      queue_access(OP_PUT, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
      // single entry, equal counts: older entry goes first
      set_capacity(5'd1);
      queue_access(OP_PUT, 31'd3, 32'd3);
      queue_access(OP_PUT, 31'd4, 32'd4);
      queue_access(OP_GET, 31'd3, '0);
      queue_access(OP_GET, 31'd4, '0);

      for (int p = 0; p < 11; p++)
         run_random(5'(phase_cap[p]), phase_n[p], phase_base[p], phase_span[p], phase_calm[p]);

      wait_idle();
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("Checked %0d responses to %0d requests across %0d capacity writes;",
               checked_count, accepted_count, cap_writes);
      $display("  %0d hits and %0d evictions were predicted.", hit_total, evict_total);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses missing", failures, expected_results.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/lfu_pkg.sv
sv/lfu_req_if.sv
sv/lfu_rsp_if.sv
sv/lfu_entry_ram.sv
sv/lfu_scan.sv
sv/lfu_cache_policy.sv
dv/tb.sv
